// ===== src/adu_pkg.sv =====
// Package with formats, function codes, stage types and divider step for the activation unit.
package adu_pkg;

   localparam int VALUE_WIDTH   = 16;
   localparam int FRACTION_BITS = 12;
   // Magnitude width holds |x|, ONE and ONE + |x| with headroom.
   localparam int MAG_WIDTH = ((VALUE_WIDTH > FRACTION_BITS) ? VALUE_WIDTH : FRACTION_BITS) + 2;
   // Internal signed width holds every product and sum before saturation.
   localparam int RES_WIDTH = 2 * MAG_WIDTH + 4;
   localparam int DEPTH     = FRACTION_BITS + 2;
   localparam int IDX_WIDTH = $clog2(DEPTH);

   localparam logic signed [RES_WIDTH-1:0] ONE_RES =
      {{(RES_WIDTH-1){1'b0}}, 1'b1} << FRACTION_BITS;
   localparam logic [MAG_WIDTH-1:0] ONE_MAG =
      {{(MAG_WIDTH-1){1'b0}}, 1'b1} << FRACTION_BITS;
   localparam logic signed [RES_WIDTH-1:0] SAT_HI =
      ({{(RES_WIDTH-1){1'b0}}, 1'b1} << (VALUE_WIDTH - 1)) - 1;
   localparam logic signed [RES_WIDTH-1:0] SAT_LO = -SAT_HI - 1;

   // Function codes as held in the default register and in the pipeline.
   localparam logic [1:0] FN_TANH      = 2'd0;
   localparam logic [1:0] FN_SIGMOID   = 2'd1;
   localparam logic [1:0] FN_SOFTSIGN  = 2'd2;
   localparam logic [1:0] FN_RECTIFIER = 2'd3;

   // Selector codes carried by each input beat.
   localparam logic [2:0] SEL_DEFAULT   = 3'd0;
   localparam logic [2:0] SEL_TANH      = 3'd1;
   localparam logic [2:0] SEL_SIGMOID   = 3'd2;
   localparam logic [2:0] SEL_SOFTSIGN  = 3'd3;
   localparam logic [2:0] SEL_RECTIFIER = 3'd4;

   // Register address decode.
   localparam logic REG_DEFAULT_FUNCTION = 1'b0;

   typedef struct packed {
      logic                          kind;
      logic [1:0]                    fn;
      logic                          bad;
      logic signed [VALUE_WIDTH-1:0] x;
   } entry_type;

   typedef struct packed {
      logic                        kind;
      logic [1:0]                  fn;
      logic                        bad;
      logic                        neg;
      logic signed [RES_WIDTH-1:0] gen;
      logic [MAG_WIDTH-1:0]        rem;
      logic [MAG_WIDTH-1:0]        dvs;
      logic [FRACTION_BITS-1:0]    quo;
   } stage_type;

   // One restoring division step: returns {remainder, quotient}.
   function automatic logic [MAG_WIDTH+FRACTION_BITS-1:0] div_step(
      input logic [MAG_WIDTH-1:0]     rem,
      input logic [MAG_WIDTH-1:0]     dvs,
      input logic [FRACTION_BITS-1:0] quo
   );
      logic [MAG_WIDTH:0]       sh;
      logic [MAG_WIDTH:0]       diff;
      logic [MAG_WIDTH-1:0]     rem_n;
      logic [FRACTION_BITS-1:0] quo_n;
      sh   = {rem, 1'b0};
      diff = sh - {1'b0, dvs};
      if (sh >= {1'b0, dvs}) begin
         rem_n = diff[MAG_WIDTH-1:0];
         quo_n = {quo[FRACTION_BITS-2:0], 1'b1};
      end else begin
         rem_n = sh[MAG_WIDTH-1:0];
         quo_n = {quo[FRACTION_BITS-2:0], 1'b0};
      end
      return {rem_n, quo_n};
   endfunction

endpackage

// ===== src/adu_req_if.sv =====
// Input channel interface: one operand beat with its selector.
interface adu_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   kind;
   logic [2:0]                             function_select;
   logic signed [adu_pkg::VALUE_WIDTH-1:0] operand_value;

   modport source (output valid, kind, function_select, operand_value, input ready);
   modport sink   (input valid, kind, function_select, operand_value, output ready);
endinterface

// ===== src/adu_rsp_if.sv =====
// Result channel interface: one result beat with its error flag.
interface adu_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [adu_pkg::VALUE_WIDTH-1:0] result_value;
   logic                                   bad_function;

   modport source (output valid, result_value, bad_function, input ready);
   modport sink   (input valid, result_value, bad_function, output ready);
endinterface

// ===== src/activation_and_derivative_unit.sv =====
// Top level of the pipelined activation and derivative unit.
//
// Each input beat on req_bus carries kind, function_select and a signed
// Q4.12 operand_value. The unit returns one beat on rsp_bus per input beat,
// in order, with the saturated result_value and the bad_function flag.
// Selector zero uses the default_function register, written over the APB
// port at byte address 0. Undefined selectors return zero with the flag set.
//
// The pipeline holds FRACTION_BITS + 2 register stages (14 at the default
// format): one input register, one restoring-division stage per quotient
// bit of the softsign divider, and the saturating output register. Every
// other function rides the same pipeline so results stay in order, and
// throughput is one beat per cycle while the receiver does not stall.
//
// Each stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls. When
// rsp_bus.ready is low the held result stays stable and req_bus.ready drops
// only once every stage is full. Reset empties the pipeline and sets the
// default function to tanh.
module activation_and_derivative_unit (
   input  logic        clock,
   input  logic        reset,
   adu_req_if.sink     req_bus,
   adu_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import adu_pkg::*;

   localparam int LAST = DEPTH - 1;

   logic [1:0]                    default_fn_ff;
   logic [DEPTH-1:0]              vld_ff;
   logic [DEPTH-1:0]              en;
   entry_type                     entry_ff, entry_in;
   stage_type                     pipe_ff [1:FRACTION_BITS];
   stage_type                     pipe_in [1:FRACTION_BITS];
   logic signed [VALUE_WIDTH-1:0] result_ff, result_in;
   logic                          bad_ff, bad_in;

   logic signed [RES_WIDTH-1:0]   core_gen;
   logic [MAG_WIDTH-1:0]          core_mag;
   logic                          core_neg;
   logic [MAG_WIDTH-1:0]          first_dvs;
   logic [MAG_WIDTH+FRACTION_BITS-1:0] step_out [1:FRACTION_BITS];
   logic signed [RES_WIDTH-1:0]   soft_val, pick_val;

   // Configuration port: pready tied high, one register.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_DEFAULT_FUNCTION) ? {30'd0, default_fn_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_fn_ff <= FN_TANH;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEFAULT_FUNCTION) begin
         default_fn_ff <= pwdata[1:0];
      end
   end

   // Stall chain from the output register back to the input.
   always_comb begin
      en[LAST] = !vld_ff[LAST] || rsp_bus.ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end
   assign req_bus.ready = en[0];

   // Selector decode into the input register.
   always_comb begin
      entry_in.kind = req_bus.kind;
      entry_in.x    = req_bus.operand_value;
      entry_in.bad  = 1'b0;
      unique case (req_bus.function_select)
         SEL_DEFAULT:   entry_in.fn = default_fn_ff;
         SEL_TANH:      entry_in.fn = FN_TANH;
         SEL_SIGMOID:   entry_in.fn = FN_SIGMOID;
         SEL_SOFTSIGN:  entry_in.fn = FN_SOFTSIGN;
         SEL_RECTIFIER: entry_in.fn = FN_RECTIFIER;
         default: begin
            entry_in.fn  = FN_TANH;
            entry_in.bad = 1'b1;
         end
      endcase
   end

   adu_core u_core (
      .kind (entry_ff.kind),
      .fn   (entry_ff.fn),
      .x    (entry_ff.x),
      .gen  (core_gen),
      .mag  (core_mag),
      .neg  (core_neg)
   );

   // First stage takes the core result and the first quotient bit; the
   // following stages each resolve one more bit of |x|*ONE / (ONE + |x|).
   always_comb begin
      first_dvs   = ONE_MAG + core_mag;
      step_out[1] = div_step(core_mag, first_dvs, '0);
      pipe_in[1].kind = entry_ff.kind;
      pipe_in[1].fn   = entry_ff.fn;
      pipe_in[1].bad  = entry_ff.bad;
      pipe_in[1].neg  = core_neg;
      pipe_in[1].gen  = core_gen;
      pipe_in[1].dvs  = first_dvs;
      pipe_in[1].rem  = step_out[1][MAG_WIDTH+FRACTION_BITS-1:FRACTION_BITS];
      pipe_in[1].quo  = step_out[1][FRACTION_BITS-1:0];
      for (int k = 2; k <= FRACTION_BITS; k++) begin
         step_out[k] = div_step(pipe_ff[k-1].rem, pipe_ff[k-1].dvs, pipe_ff[k-1].quo);
         pipe_in[k]     = pipe_ff[k-1];
         pipe_in[k].rem = step_out[k][MAG_WIDTH+FRACTION_BITS-1:FRACTION_BITS];
         pipe_in[k].quo = step_out[k][FRACTION_BITS-1:0];
      end
   end

   // Output selection and saturation.
   always_comb begin
      soft_val = RES_WIDTH'(pipe_ff[FRACTION_BITS].quo);
      if (pipe_ff[FRACTION_BITS].neg) begin
         soft_val = -soft_val;
      end
      if (pipe_ff[FRACTION_BITS].bad) begin
         pick_val = '0;
      end else if (!pipe_ff[FRACTION_BITS].kind && pipe_ff[FRACTION_BITS].fn == FN_SOFTSIGN) begin
         pick_val = soft_val;
      end else begin
         pick_val = pipe_ff[FRACTION_BITS].gen;
      end
      if (pick_val > SAT_HI) begin
         result_in = SAT_HI[VALUE_WIDTH-1:0];
      end else if (pick_val < SAT_LO) begin
         result_in = SAT_LO[VALUE_WIDTH-1:0];
      end else begin
         result_in = pick_val[VALUE_WIDTH-1:0];
      end
      bad_in = pipe_ff[FRACTION_BITS].bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         entry_ff <= entry_in;
      end
      for (int k = 1; k <= FRACTION_BITS; k++) begin
         if (en[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (en[LAST]) begin
         result_ff <= result_in;
         bad_ff    <= bad_in;
      end
   end

   assign rsp_bus.valid        = vld_ff[LAST];
   assign rsp_bus.result_value = result_ff;
   assign rsp_bus.bad_function = bad_ff;

endmodule

// ===== src/adu_core.sv =====
// Shift-and-add sigmoid and tanh, rectifier, and the derivative multiplier.
module adu_core (
   input  logic                                   kind,
   input  logic [1:0]                             fn,
   input  logic signed [adu_pkg::VALUE_WIDTH-1:0] x,
   output logic signed [adu_pkg::RES_WIDTH-1:0]   gen,
   output logic [adu_pkg::MAG_WIDTH-1:0]          mag,
   output logic                                   neg
);
   import adu_pkg::*;

   localparam logic signed [RES_WIDTH-1:0] T_SAT  = ONE_RES * 5;
   localparam logic signed [RES_WIDTH-1:0] T_MID  = (ONE_RES * 19) / 8;
   localparam logic signed [RES_WIDTH-1:0] C_HIGH = (ONE_RES * 27) / 32;
   localparam logic signed [RES_WIDTH-1:0] C_MID  = (ONE_RES * 5) / 8;
   localparam logic signed [RES_WIDTH-1:0] C_LOW  = ONE_RES / 2;

   logic signed [RES_WIDTH-1:0]   xe, arg, sa, sm, sg, act_tanh;
   logic signed [RES_WIDTH-1:0]   p, q, pa, qa, fa, sn, mext;
   logic [MAG_WIDTH-1:0]          mp, mq;
   logic [2*MAG_WIDTH-1:0]        prod;
   logic                          pneg;

   always_comb begin
      xe  = {{(RES_WIDTH-VALUE_WIDTH){x[VALUE_WIDTH-1]}}, x};
      arg = (fn == FN_TANH) ? (xe <<< 1) : xe;
      sa  = (arg < 0) ? -arg : arg;
      if (sa >= T_SAT) begin
         sm = ONE_RES;
      end else if (sa >= T_MID) begin
         sm = (sa >>> 5) + C_HIGH;
      end else if (sa >= ONE_RES) begin
         sm = (sa >>> 3) + C_MID;
      end else begin
         sm = (sa >>> 2) + C_LOW;
      end
      sg       = (arg < 0) ? ONE_RES - sm : sm;
      act_tanh = (sg <<< 1) - ONE_RES;

      // Operands of the single shared product for the derivatives.
      fa = (xe < 0) ? -xe : xe;
      case (fn)
         FN_TANH: begin
            p = xe;
            q = xe;
         end
         FN_SIGMOID: begin
            p = xe;
            q = ONE_RES - xe;
         end
         default: begin
            p = ONE_RES - fa;
            q = ONE_RES - fa;
         end
      endcase
      pneg = (p < 0) != (q < 0);
      pa   = (p < 0) ? -p : p;
      qa   = (q < 0) ? -q : q;
      mp   = pa[MAG_WIDTH-1:0];
      mq   = qa[MAG_WIDTH-1:0];
      prod = mp * mq;
      mext = RES_WIDTH'(prod >> FRACTION_BITS);
      sn   = pneg ? -mext : mext;

      if (kind) begin
         case (fn)
            FN_TANH:    gen = ONE_RES - sn;
            FN_SIGMOID: gen = sn;
            FN_SOFTSIGN: gen = sn;
            default:    gen = (xe == 0) ? '0 : ONE_RES;
         endcase
      end else begin
         case (fn)
            FN_TANH:    gen = act_tanh;
            FN_SIGMOID: gen = sg;
            FN_SOFTSIGN: gen = '0;
            default:    gen = (xe > 0) ? xe : '0;
         endcase
      end

      mag = fa[MAG_WIDTH-1:0];
      neg = x[VALUE_WIDTH-1];
   end
endmodule

// ===== src/adu_checker.sv =====
// Port-level checker for the activation unit and its bind statement.
module adu_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [adu_pkg::VALUE_WIDTH-1:0] rsp_result_value,
   input logic                                   rsp_bad_function
);
   import adu_pkg::*;

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // An undefined selector always yields a zero result.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_function |-> rsp_result_value == 0)
      else $error("bad function beat carries a nonzero result");

   // The input side only stalls when the output is full and held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the output could move");

   // A held result beat does not change.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_bad_function))
      else $error("held result beat changed");
endmodule

bind activation_and_derivative_unit adu_checker u_adu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_value (rsp_bus.result_value),
   .rsp_bad_function (rsp_bus.bad_function)
);

// ===== sim/adu_checker.sv =====
`timescale 1ns / 1ps
// Checker that watches both channels, predicts every result and compares it.
module adu_scoreboard (
   input  logic        clock,
   input  logic        reset,
   adu_req_if          req_bus,
   adu_rsp_if          rsp_bus,
   input  logic [1:0]  default_fn,
   output int          fail_count,
   output int          pending_count
);
   import adu_pkg::*;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          bad;
   } outcome_type;

   outcome_type outcome_queue[$];

   localparam longint ONE = longint'(1) << FRACTION_BITS;

   function automatic longint clamp_value(longint v);
      longint hi;
      hi = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint fixed_mul(longint p, longint q);
      longint m;
      m = ((p < 0 ? -p : p) * (q < 0 ? -q : q)) >>> FRACTION_BITS;
      return ((p < 0) != (q < 0)) ? -m : m;
   endfunction

   function automatic longint sigmoid_of(longint x);
      longint a, s;
      a = x < 0 ? -x : x;
      if (a >= 5 * ONE) s = ONE;
      else if (a >= (19 * ONE) / 8) s = (a >>> 5) + (27 * ONE) / 32;
      else if (a >= ONE) s = (a >>> 3) + (5 * ONE) / 8;
      else s = (a >>> 2) + ONE / 2;
      return x < 0 ? ONE - s : s;
   endfunction

   function automatic outcome_type predict_result(logic kind, logic [2:0] sel,
                                                  logic signed [VALUE_WIDTH-1:0] operand,
                                                  logic [1:0] dflt);
      outcome_type o;
      logic [1:0] fn;
      longint x, r, a, d;
      o.bad = 1'b0;
      if (sel > SEL_RECTIFIER) begin
         o.value = '0;
         o.bad   = 1'b1;
         return o;
      end
      fn = (sel == SEL_DEFAULT) ? dflt : 2'(sel - 3'd1);
      x  = longint'(operand);
      a  = x < 0 ? -x : x;
      if (!kind) begin
         case (fn)
            FN_TANH:     r = 2 * sigmoid_of(2 * x) - ONE;
            FN_SIGMOID:  r = sigmoid_of(x);
            FN_SOFTSIGN: begin
               r = (a * ONE) / (ONE + a);
               if (x < 0) r = -r;
            end
            default:     r = x > 0 ? x : 0;
         endcase
      end else begin
         case (fn)
            FN_TANH:     r = ONE - fixed_mul(x, x);
            FN_SIGMOID:  r = fixed_mul(x, ONE - x);
            FN_SOFTSIGN: begin
               d = ONE - a;
               r = fixed_mul(d, d);
            end
            default:     r = x == 0 ? 0 : ONE;
         endcase
      end
      o.value = VALUE_WIDTH'(clamp_value(r));
      return o;
   endfunction

   assign pending_count = outcome_queue.size();

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         outcome_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            outcome_queue = {outcome_queue,
                             predict_result(req_bus.kind, req_bus.function_select,
                                            req_bus.operand_value, default_fn)};
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outcome_queue.size() == 0) begin
               if (fail_count < 10) $display("Unexpected result beat %0d", rsp_bus.result_value);
               fail_count <= fail_count + 1;
            end else begin
               want = outcome_queue.pop_front();
               if (want.value !== rsp_bus.result_value || want.bad !== rsp_bus.bad_function) begin
                  if (fail_count < 10)
                     $display("Mismatch: expected value %0d bad %0b, got value %0d bad %0b",
                              want.value, want.bad, rsp_bus.result_value, rsp_bus.bad_function);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, stimulus, register writes and verdict.
module testbench;
   import adu_pkg::*;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;
   logic [1:0]  default_fn;
   int          fail_count, pending_count;

   // Receiver control: idle percentage and a long hold-off request, which
   // is raised by bumping the token.
   int          sink_idle_pct;
   int          hold_token;
   int          hold_cycles;

   adu_req_if req_bus ();
   adu_rsp_if rsp_bus ();

   activation_and_derivative_unit u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // The checker sees the default function the testbench has written last;
   // writes only happen while the pipeline is empty, so this is exact.
   adu_scoreboard u_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .default_fn(default_fn), .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // The receiver stalls at random, except while a long hold-off runs, when
   // it keeps ready low for a counted number of cycles so the pipe fills.
   initial begin
      int hold_seen;
      hold_seen     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // One register write: setup cycle, then access cycle.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      default_fn = data[1:0];
   endtask

   // Offer one beat and hold it until the block accepts it. The valid stays
   // high across back-to-back beats; a random gap lowers it first.
   task automatic send_operand(input logic kind, input logic [2:0] sel,
                               input logic [VALUE_WIDTH-1:0] operand, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.kind            <= kind;
      req_bus.function_select <= sel;
      req_bus.operand_value   <= operand;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Lower valid and wait until every predicted result has come back,
   // then idle on for good measure.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (FRACTION_BITS + 4) @(posedge clock);
   endtask

   // Random operand: equally often spread over the whole range, near zero,
   // near the sigmoid breakpoints within [-6, 6], or activated values within [-1, 1].
   function automatic logic [VALUE_WIDTH-1:0] random_operand();
      case ($urandom_range(3))
         0: return VALUE_WIDTH'($urandom);
         1: return VALUE_WIDTH'($signed($urandom_range(2 * 6 * 4096)) - 6 * 4096);
         2: return VALUE_WIDTH'($signed($urandom_range(2 * 4096)) - 4096);
         default: return VALUE_WIDTH'($signed($urandom_range(64)) - 32);
      endcase
   endfunction

   initial begin
      logic [VALUE_WIDTH-1:0] directed_values[12];
      logic [1:0]  phase_fn[5];
      logic [2:0]  sel;
      int          idle_pct;
      directed_values = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h1000,
                          16'hf000, 16'h5000, 16'h2600, 16'hda00, 16'h0800, 16'h1001};
      phase_fn = '{FN_TANH, FN_RECTIFIER, FN_SIGMOID, FN_SOFTSIGN, FN_TANH};
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      default_fn    = FN_TANH;
      hold_token    = 0;
      hold_cycles   = 0;
      sink_idle_pct = 30;
      req_bus.valid = 1'b0;
      req_bus.kind  = 1'b0;
      req_bus.function_select = SEL_DEFAULT;
      req_bus.operand_value   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes and breakpoints through every function, tanh and softsign
      // as activations and sigmoid and rectifier as derivatives, plus each undefined selector code.
      for (int i = 0; i < 12; i++)
         send_operand(i[0], 3'(1 + (i % 4)), directed_values[i], 0);
      for (int s = 5; s < 8; s++) send_operand(1'b0, 3'(s), 16'h7fff, 0);
      send_operand(1'b1, SEL_DEFAULT, 16'h8000, 0);
      send_operand(1'b0, SEL_DEFAULT, 16'h8000, 0);
      // Sender pauses until every result is back.
      drain_pipeline();

      for (int p = 0; p < 5; p++) begin
         write_register(3'(4 * REG_DEFAULT_FUNCTION), 32'(phase_fn[p]));
         // A long receiver hold-off while the sender keeps offering beats.
         if (p == 1) begin
            hold_cycles = 60;
            hold_token  = hold_token + 1;
         end
         // Phase 3 runs with no idling at all on either side.
         idle_pct      = (p == 3) ? 0 : 30;
         sink_idle_pct = idle_pct;
         for (int n = 0; n < 250; n++) begin
            sel = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
            send_operand(1'($urandom), sel, random_operand(), idle_pct);
         end
         drain_pipeline();
      end
      sink_idle_pct = 30;

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
